[rtl/ts_hdr_pkg.sv]
// Shared types, constants, the item-advance function and the clock repack function of the TS packet header parser.
package ts_hdr_pkg;

  // Parameter default: bytes of a packet that are parsed at most
  localparam int PacketBytesMaxDef = 188;

  // Field widths of the result record
  localparam int HeaderW  = 32;
  localparam int MaskW    = 5;
  localparam int ClockW   = 42;
  localparam int RawClkW  = 48;
  localparam int SpanW    = 16;

  // Walk phase over the adaptation field items, in spec order
  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_PCR    = 3'd1,
    PH_OPCR   = 3'd2,
    PH_SPLICE = 3'd3,
    PH_PRIV   = 3'd4,
    PH_EXT    = 3'd5,
    PH_SKIP   = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  // Bits of the present mask
  localparam int PresPcr    = 0;
  localparam int PresOpcr   = 1;
  localparam int PresSplice = 2;
  localparam int PresPriv   = 3;
  localparam int PresExt    = 4;

  // Header byte bit that flags an adaptation field
  localparam int AfcAfBit = 5;

  // Outcome of a move to the next flagged item
  typedef struct packed {
    phase_e phase;
    logic   fail;
    logic   load_six;
  } adv_t;

  // Result record
  typedef struct packed {
    logic               parse_ok;
    logic [HeaderW-1:0] header_word;
    logic [7:0]         af_length;
    logic [7:0]         af_flags;
    logic [MaskW-1:0]   present_mask;
    logic [ClockW-1:0]  pcr_value;
    logic [ClockW-1:0]  opcr_value;
    logic [7:0]         splice_count;
    logic [SpanW-1:0]   private_span;
    logic [SpanW-1:0]   extension_span;
    logic [7:0]         payload_start;
    logic [7:0]         payload_bytes;
  } rec_t;

  // Find the first flagged item after 'after' and check its bound against
  // the next byte index. Flag bit 4 is PCR down to bit 0 for the extension.
  function automatic adv_t adv_f(input logic [7:0] flags, input phase_e after,
                                 input logic [8:0] nidx, input logic [8:0] end_idx);
    adv_t r;
    logic found;
    r.phase    = PH_DONE;
    r.fail     = 1'b0;
    r.load_six = 1'b0;
    found      = 1'b0;
    for (int k = 1; k <= 5; k++) begin
      if (!found && (k > int'(after)) && flags[5-k]) begin
        found = 1'b1;
        if (k <= 2) begin
          // Clock reference items need six bytes inside the field
          if (({1'b0, nidx} + 10'd6) > {1'b0, end_idx}) begin
            r.fail = 1'b1;
          end else begin
            r.phase    = phase_e'(3'(k));
            r.load_six = 1'b1;
          end
        end else begin
          if (nidx >= end_idx) begin
            r.fail = 1'b1;
          end else begin
            r.phase = phase_e'(3'(k));
          end
        end
      end
    end
    return r;
  endfunction

  // Repack a raw 48-bit clock reference: 33-bit base over 9-bit extension
  function automatic logic [ClockW-1:0] pack_clk_f(input logic [RawClkW-1:0] raw);
    return {raw[47:15], raw[8:0]};
  endfunction

endpackage

[rtl/ts_hdr_in_if.sv]
// Byte channel into the parser: one packet byte per beat.
interface ts_hdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/ts_hdr_out_if.sv]
// Record channel out of the parser: one parsed packet per beat.
interface ts_hdr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             parse_ok;
  logic [ts_hdr_pkg::HeaderW-1:0]   header_word;
  logic [7:0]                       af_length;
  logic [7:0]                       af_flags;
  logic [ts_hdr_pkg::MaskW-1:0]     present_mask;
  logic [ts_hdr_pkg::ClockW-1:0]    pcr_value;
  logic [ts_hdr_pkg::ClockW-1:0]    opcr_value;
  logic [7:0]                       splice_count;
  logic [ts_hdr_pkg::SpanW-1:0]     private_span;
  logic [ts_hdr_pkg::SpanW-1:0]     extension_span;
  logic [7:0]                       payload_start;
  logic [7:0]                       payload_bytes;

  modport source (output valid, output parse_ok, output header_word, output af_length,
                  output af_flags, output present_mask, output pcr_value,
                  output opcr_value, output splice_count, output private_span,
                  output extension_span, output payload_start, output payload_bytes,
                  input ready);
  modport sink   (input valid, input parse_ok, input header_word, input af_length,
                  input af_flags, input present_mask, input pcr_value,
                  input opcr_value, input splice_count, input private_span,
                  input extension_span, input payload_start, input payload_bytes,
                  output ready);
endinterface

[rtl/ts_packet_header_parser.sv]
// TS packet header and adaptation field parser, top level.
//
//   channel  dir  beat                          payload
//   pkt_i    in   one packet byte               data_byte, last_byte
//   rec_o    out  one record per packet         parse_ok .. payload_bytes
//
// One byte is taken per cycle while pkt_i.ready is high; the record of a packet is registered on the
// edge that takes its last byte and shows on rec_o the cycle after.
// The walk state and the record register sit one byte-step apart, so a new
// packet may start in the cycle right after a last byte.
// pkt_i stalls only while a finished record waits on rec_o and rec_o.ready
// is low. rst_ni clears the walk state and the record valid at once.
module ts_packet_header_parser #(
  parameter int PACKET_BYTES_MAX = ts_hdr_pkg::PacketBytesMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ts_hdr_in_if.sink           pkt_i,
  ts_hdr_out_if.source        rec_o
);

  localparam logic [7:0] PmaxB = 8'(PACKET_BYTES_MAX);

  // Walk state
  logic [7:0]                     byte_index_q, byte_index_d;
  logic [ts_hdr_pkg::HeaderW-1:0] header_q, header_d;
  logic [7:0]                     af_len_q, af_len_d;
  logic [7:0]                     af_flags_q, af_flags_d;
  ts_hdr_pkg::phase_e             phase_q, phase_d;
  logic [7:0]                     remaining_q, remaining_d;
  logic [ts_hdr_pkg::RawClkW-1:0] pcr_q, pcr_d;
  logic [ts_hdr_pkg::RawClkW-1:0] opcr_q, opcr_d;
  logic [7:0]                     splice_q, splice_d;
  logic [ts_hdr_pkg::SpanW-1:0]   private_q, private_d;
  logic [ts_hdr_pkg::SpanW-1:0]   ext_q, ext_d;
  logic [ts_hdr_pkg::MaskW-1:0]   valid_q, valid_d;
  logic                           fail_q, fail_d;

  // Output register
  logic                           rec_valid_q;
  ts_hdr_pkg::rec_t               rec_q, rec_d;

  logic                           in_acc;
  logic                           take;
  logic [7:0]                     b;
  logic [8:0]                     nidx;
  logic [8:0]                     af_end_now;
  logic                           adv_req;
  ts_hdr_pkg::phase_e             adv_from;
  logic [7:0]                     adv_flags;
  ts_hdr_pkg::adv_t               adv;

  // Record evaluation
  logic [8:0]                     len9;
  logic [1:0]                     afc;
  logic [8:0]                     af_end_new;
  logic [8:0]                     start9;
  logic                           ok;

  // Accept a byte whenever the record register is free or draining
  assign pkt_i.ready = !rec_valid_q || rec_o.ready;
  assign in_acc      = pkt_i.valid && pkt_i.ready;
  assign take        = in_acc && (byte_index_q < PmaxB);
  assign b           = pkt_i.data_byte;
  assign nidx        = 9'(byte_index_q) + 9'd1;
  assign af_end_now  = 9'(af_len_q) + 9'd5;

  // Walk next state: consume one byte in the current phase
  always_comb begin
    byte_index_d = byte_index_q;
    header_d     = header_q;
    af_len_d     = af_len_q;
    af_flags_d   = af_flags_q;
    phase_d      = phase_q;
    remaining_d  = remaining_q;
    pcr_d        = pcr_q;
    opcr_d       = opcr_q;
    splice_d     = splice_q;
    private_d    = private_q;
    ext_d        = ext_q;
    valid_d      = valid_q;
    fail_d       = fail_q;
    adv_req      = 1'b0;
    adv_from     = phase_q;
    adv_flags    = af_flags_q;
    adv          = '0;
    if (take) begin
      byte_index_d = byte_index_q + 8'd1;
      unique case (phase_q)
        ts_hdr_pkg::PH_HEAD: begin
          if (byte_index_q < 8'd4) begin
            header_d = {header_q[23:0], b};
            if (byte_index_q == 8'd3 && !b[ts_hdr_pkg::AfcAfBit]) begin
              phase_d = ts_hdr_pkg::PH_DONE;
            end
          end else if (byte_index_q == 8'd4) begin
            af_len_d = b;
            if (b == 8'd0) begin
              phase_d = ts_hdr_pkg::PH_DONE;
            end
          end else begin
            af_flags_d = b;
            adv_flags  = b;
            adv_req    = 1'b1;
          end
        end
        ts_hdr_pkg::PH_PCR, ts_hdr_pkg::PH_OPCR: begin
          if (phase_q == ts_hdr_pkg::PH_PCR) begin
            pcr_d = {pcr_q[39:0], b};
          end else begin
            opcr_d = {opcr_q[39:0], b};
          end
          remaining_d = remaining_q - 8'd1;
          if (remaining_q == 8'd1) begin
            if (phase_q == ts_hdr_pkg::PH_PCR) begin
              valid_d[ts_hdr_pkg::PresPcr] = 1'b1;
            end else begin
              valid_d[ts_hdr_pkg::PresOpcr] = 1'b1;
            end
            adv_req = 1'b1;
          end
        end
        ts_hdr_pkg::PH_SPLICE: begin
          splice_d = b;
          valid_d[ts_hdr_pkg::PresSplice] = 1'b1;
          adv_req = 1'b1;
        end
        ts_hdr_pkg::PH_PRIV, ts_hdr_pkg::PH_EXT: begin
          // Length byte of a span: the data must end inside the field
          if (({1'b0, nidx} + 10'(b)) > {1'b0, af_end_now}) begin
            fail_d  = 1'b1;
            phase_d = ts_hdr_pkg::PH_DONE;
          end else begin
            if (phase_q == ts_hdr_pkg::PH_PRIV) begin
              private_d = {nidx[7:0], b};
              valid_d[ts_hdr_pkg::PresPriv] = 1'b1;
            end else begin
              ext_d = {nidx[7:0], b};
              valid_d[ts_hdr_pkg::PresExt] = 1'b1;
            end
            if (b == 8'd0) begin
              adv_req = 1'b1;
            end else begin
              remaining_d = b;
              phase_d     = ts_hdr_pkg::PH_SKIP;
            end
          end
        end
        ts_hdr_pkg::PH_SKIP: begin
          remaining_d = remaining_q - 8'd1;
          if (remaining_q == 8'd1) begin
            adv_from = valid_q[ts_hdr_pkg::PresExt] ? ts_hdr_pkg::PH_EXT
                                                    : ts_hdr_pkg::PH_PRIV;
            adv_req  = 1'b1;
          end
        end
        ts_hdr_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
      // Move on to the next flagged item
      adv = ts_hdr_pkg::adv_f(adv_flags, adv_from, nidx, af_end_now);
      if (adv_req) begin
        phase_d = adv.phase;
        if (adv.fail) begin
          fail_d = 1'b1;
        end
        if (adv.load_six) begin
          remaining_d = 8'd6;
        end
      end
    end
  end

  // Record of the packet as it stands after this byte
  always_comb begin
    rec_d      = '0;
    len9       = 9'(byte_index_d);
    afc        = header_d[5:4];
    af_end_new = 9'(af_len_d) + 9'd5;
    start9     = afc[1] ? af_end_new : 9'd4;
    ok         = 1'b1;
    if (len9 >= 9'd4) begin
      rec_d.header_word = header_d;
      if (afc[1]) begin
        if (len9 < af_end_new) begin
          ok = 1'b0;
        end else begin
          rec_d.af_length    = af_len_d;
          rec_d.af_flags     = (af_len_d != 8'd0) ? af_flags_d : 8'd0;
          rec_d.present_mask = valid_d;
          if (valid_d[ts_hdr_pkg::PresPcr]) begin
            rec_d.pcr_value = ts_hdr_pkg::pack_clk_f(pcr_d);
          end
          if (valid_d[ts_hdr_pkg::PresOpcr]) begin
            rec_d.opcr_value = ts_hdr_pkg::pack_clk_f(opcr_d);
          end
          if (valid_d[ts_hdr_pkg::PresSplice]) begin
            rec_d.splice_count = splice_d;
          end
          if (valid_d[ts_hdr_pkg::PresPriv]) begin
            rec_d.private_span = private_d;
          end
          if (valid_d[ts_hdr_pkg::PresExt]) begin
            rec_d.extension_span = ext_d;
          end
          if (fail_d) begin
            ok = 1'b0;
          end
        end
      end
      if (ok && afc[0] && (len9 >= start9)) begin
        rec_d.payload_start = start9[7:0];
        rec_d.payload_bytes = 8'(len9 - start9);
      end
      rec_d.parse_ok = ok;
    end
  end

  // Walk state: advance per byte, clear after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      header_q     <= '0;
      af_len_q     <= '0;
      af_flags_q   <= '0;
      phase_q      <= ts_hdr_pkg::PH_HEAD;
      remaining_q  <= '0;
      pcr_q        <= '0;
      opcr_q       <= '0;
      splice_q     <= '0;
      private_q    <= '0;
      ext_q        <= '0;
      valid_q      <= '0;
      fail_q       <= 1'b0;
    end else if (in_acc) begin
      if (pkt_i.last_byte) begin
        byte_index_q <= '0;
        header_q     <= '0;
        af_len_q     <= '0;
        af_flags_q   <= '0;
        phase_q      <= ts_hdr_pkg::PH_HEAD;
        remaining_q  <= '0;
        pcr_q        <= '0;
        opcr_q       <= '0;
        splice_q     <= '0;
        private_q    <= '0;
        ext_q        <= '0;
        valid_q      <= '0;
        fail_q       <= 1'b0;
      end else begin
        byte_index_q <= byte_index_d;
        header_q     <= header_d;
        af_len_q     <= af_len_d;
        af_flags_q   <= af_flags_d;
        phase_q      <= phase_d;
        remaining_q  <= remaining_d;
        pcr_q        <= pcr_d;
        opcr_q       <= opcr_d;
        splice_q     <= splice_d;
        private_q    <= private_d;
        ext_q        <= ext_d;
        valid_q      <= valid_d;
        fail_q       <= fail_d;
      end
    end
  end

  // Record valid: set on a last byte, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else if (in_acc && pkt_i.last_byte) begin
      rec_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      rec_valid_q <= 1'b0;
    end
  end

  // Record payload: load on a last byte
  always_ff @(posedge clk_i) begin
    if (in_acc && pkt_i.last_byte) begin
      rec_q <= rec_d;
    end
  end

  // Drive the record channel
  assign rec_o.valid          = rec_valid_q;
  assign rec_o.parse_ok       = rec_q.parse_ok;
  assign rec_o.header_word    = rec_q.header_word;
  assign rec_o.af_length      = rec_q.af_length;
  assign rec_o.af_flags       = rec_q.af_flags;
  assign rec_o.present_mask   = rec_q.present_mask;
  assign rec_o.pcr_value      = rec_q.pcr_value;
  assign rec_o.opcr_value     = rec_q.opcr_value;
  assign rec_o.splice_count   = rec_q.splice_count;
  assign rec_o.private_span   = rec_q.private_span;
  assign rec_o.extension_span = rec_q.extension_span;
  assign rec_o.payload_start  = rec_q.payload_start;
  assign rec_o.payload_bytes  = rec_q.payload_bytes;

`ifndef SYNTH
  // A last byte always produces a record in the next cycle
  a_last_gives_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pkt_i.last_byte) |=> rec_o.valid)
    else $error("last byte did not produce a record");

  // The walk restarts at the head after each packet
  a_walk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pkt_i.last_byte) |=>
      (byte_index_q == 8'd0 && phase_q == ts_hdr_pkg::PH_HEAD && valid_q == '0))
    else $error("walk state not cleared after a packet");

  // The byte count saturates at the packet limit
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= PmaxB)
    else $error("byte index beyond packet limit");

  // A failed parse reports no payload
  a_fail_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && !rec_o.parse_ok) |->
      (rec_o.payload_start == 8'd0 && rec_o.payload_bytes == 8'd0))
    else $error("payload reported on a failed parse");

  // An absent PCR reads as zero
  a_absent_pcr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && !rec_o.present_mask[ts_hdr_pkg::PresPcr]) |->
      (rec_o.pcr_value == '0))
    else $error("PCR value set while not present");
`endif

endmodule
